// File: hdl/cos_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Console option scanner package
// Field widths, port addresses and the console prefix text shared by the
// channel interfaces and the scanner.
// ----------------------------------------------------------------------------
package cos_pkg;

    localparam int CHAR_W = 8;
    localparam int PORT_W = 10;
    localparam int BAUD_W = 31;
    localparam int MATCH_W = 4;

    localparam logic [PORT_W-1:0] PORT_A = 10'h3F8;
    localparam logic [PORT_W-1:0] PORT_B = 10'h2F8;
    localparam logic [BAUD_W-1:0] RESET_BAUD = 31'd115200;
    localparam logic [BAUD_W-1:0] BAUD_MAX = 31'h7FFF_FFFF;

    // Length of the text "console=ttyS".
    localparam logic [MATCH_W-1:0] PREFIX_LEN = 4'd12;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    typedef logic [CHAR_W-1:0] char_t;

    function automatic char_t prefix_char(input logic [MATCH_W-1:0] pos);
        char_t ch;
        case (pos)
            4'd0:    ch = 8'h63; // c
            4'd1:    ch = 8'h6F; // o
            4'd2:    ch = 8'h6E; // n
            4'd3:    ch = 8'h73; // s
            4'd4:    ch = 8'h6F; // o
            4'd5:    ch = 8'h6C; // l
            4'd6:    ch = 8'h65; // e
            4'd7:    ch = 8'h3D; // =
            4'd8:    ch = 8'h74; // t
            4'd9:    ch = 8'h74; // t
            4'd10:   ch = 8'h79; // y
            4'd11:   ch = 8'h53; // S
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

// File: hdl/cos_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Console option scanner character channel
// Carries one command-line byte and its line framing flags per request.
// ----------------------------------------------------------------------------
interface cos_in_if;
    logic                        valid;
    logic                        ready;
    logic [cos_pkg::CHAR_W-1:0]  char_byte;
    logic                        first_byte;
    logic                        last_byte;

    modport source (output valid, output char_byte, output first_byte,
                    output last_byte, input ready);
    modport sink (input valid, input char_byte, input first_byte,
                  input last_byte, output ready);
endinterface
`default_nettype wire

// File: hdl/cos_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Console option scanner settings channel
// Carries the console settings reported after each byte.
// ----------------------------------------------------------------------------
interface cos_out_if;
    logic                        valid;
    logic                        ready;
    logic                        console_enabled;
    logic [cos_pkg::PORT_W-1:0]  console_port;
    logic [cos_pkg::BAUD_W-1:0]  console_baud;
    logic                        line_done;

    modport source (output valid, output console_enabled, output console_port,
                    output console_baud, output line_done, input ready);
    modport sink (input valid, input console_enabled, input console_port,
                  input console_baud, input line_done, output ready);
endinterface
`default_nettype wire

// File: hdl/console_option_scanner_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Console option scanner
// Byte-wide boot command line parser for the console=ttyS option.
//
// Bytes arrive as requests on the chars channel; every byte yields one
// request on the settings channel holding the console settings after it.
// A byte is first captured in an input register and is parsed when the
// settings channel can take a new request; the result is then written to
// the settings registers, which drive the settings channel directly. One
// byte is taken every cycle while the receiver keeps up. The parse state
// and settings are updated once per byte.
// If the receiver stalls, one further byte is still captured in the input
// register; after that ready falls until the waiting request is taken.
// Reset clears both stages, disables the console and loads a baud of
// 115200, which is also the default baud after reset; cfg_we writes the
// default baud, which takes effect at the next byte flagged as the first
// of a line.
// ----------------------------------------------------------------------------
module console_option_scanner_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    cos_in_if.sink                           chars,
    cos_out_if.source                        settings,
    input  wire logic                        cfg_we,
    input  wire logic [cos_pkg::BAUD_W-1:0]  cfg_wdata
);

    localparam logic [2:0] PH_BETWEEN = 3'd0;
    localparam logic [2:0] PH_MATCH   = 3'd1;
    localparam logic [2:0] PH_DIGIT   = 3'd2;
    localparam logic [2:0] PH_BAUD    = 3'd3;
    localparam logic [2:0] PH_SKIP    = 3'd4;

    localparam int ACC_W = cos_pkg::BAUD_W + 4;

    // Input stage.
    logic                          s1_valid_reg;
    cos_pkg::char_t                s1_char_reg;
    logic                          s1_first_reg;
    logic                          s1_last_reg;

    // Parse state and settings; the settings double as the result register.
    logic                          out_valid_reg;
    logic [2:0]                    phase_reg, phase_next;
    logic [cos_pkg::MATCH_W-1:0]   match_reg, match_next;
    logic [cos_pkg::BAUD_W-1:0]    acc_reg, acc_next;
    logic                          en_reg, en_next;
    logic [cos_pkg::PORT_W-1:0]    port_reg, port_next;
    logic [cos_pkg::BAUD_W-1:0]    baud_reg, baud_next;
    logic                          ended_reg, ended_next;
    logic [cos_pkg::BAUD_W-1:0]    dflt_baud_reg;

    logic                          advance;
    logic                          is_space;
    logic                          is_digit;
    logic [ACC_W-1:0]              acc_times10;

    assign advance = s1_valid_reg && (!out_valid_reg || settings.ready);
    assign chars.ready = !s1_valid_reg || advance;

    assign is_space = (s1_char_reg == cos_pkg::CH_SPACE) || (s1_char_reg == cos_pkg::CH_TAB)
                   || (s1_char_reg == cos_pkg::CH_LF) || (s1_char_reg == cos_pkg::CH_CR);
    assign is_digit = (s1_char_reg >= cos_pkg::CH_ZERO) && (s1_char_reg <= cos_pkg::CH_NINE);

    always_comb
    begin
        phase_next = phase_reg;
        match_next = match_reg;
        acc_next   = acc_reg;
        en_next    = en_reg;
        port_next  = port_reg;
        baud_next  = baud_reg;
        ended_next = ended_reg;
        acc_times10 = '0;

        if (s1_first_reg)
        begin
            phase_next = PH_BETWEEN;
            match_next = '0;
            acc_next   = '0;
            en_next    = 1'b0;
            port_next  = '0;
            baud_next  = dflt_baud_reg;
            ended_next = 1'b0;
        end

        if (!ended_next)
        begin
            if (s1_char_reg == cos_pkg::CH_NUL)
            begin
                if (phase_next == PH_BAUD && acc_next != '0)
                begin
                    baud_next = acc_next;
                end
                phase_next = PH_BETWEEN;
                ended_next = 1'b1;
            end
            else
            begin
                if (is_space)
                begin
                    if (phase_next == PH_BAUD && acc_next != '0)
                    begin
                        baud_next = acc_next;
                    end
                    phase_next = PH_BETWEEN;
                    match_next = '0;
                end
                else
                begin
                    unique case (phase_next) inside
                        PH_BETWEEN, PH_MATCH:
                        begin
                            if (phase_next == PH_BETWEEN)
                            begin
                                match_next = '0;
                            end
                            if (match_next < cos_pkg::PREFIX_LEN)
                            begin
                                if (s1_char_reg == cos_pkg::prefix_char(match_next))
                                begin
                                    match_next = match_next + 1'b1;
                                    phase_next = PH_MATCH;
                                end
                                else
                                begin
                                    phase_next = PH_SKIP;
                                end
                            end
                            else if (s1_char_reg == cos_pkg::CH_ZERO
                                     || s1_char_reg == cos_pkg::CH_ONE)
                            begin
                                port_next  = (s1_char_reg == cos_pkg::CH_ZERO)
                                           ? cos_pkg::PORT_A : cos_pkg::PORT_B;
                                en_next    = 1'b1;
                                phase_next = PH_DIGIT;
                            end
                            else
                            begin
                                phase_next = PH_SKIP;
                            end
                        end
                        PH_DIGIT:
                        begin
                            if (s1_char_reg == cos_pkg::CH_COMMA)
                            begin
                                acc_next   = '0;
                                phase_next = PH_BAUD;
                            end
                            else
                            begin
                                phase_next = PH_SKIP;
                            end
                        end
                        PH_BAUD:
                        begin
                            if (is_digit)
                            begin
                                // Multiply by ten as two shifts, then add the digit.
                                acc_times10 = ({4'b0, acc_next} << 3)
                                            + ({4'b0, acc_next} << 1)
                                            + ACC_W'(s1_char_reg[3:0]);
                                acc_next = (acc_times10 > ACC_W'(cos_pkg::BAUD_MAX))
                                         ? cos_pkg::BAUD_MAX
                                         : acc_times10[cos_pkg::BAUD_W-1:0];
                            end
                            else
                            begin
                                if (acc_next != '0)
                                begin
                                    baud_next = acc_next;
                                end
                                phase_next = PH_SKIP;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_SKIP;
                        end
                    endcase
                end

                if (s1_last_reg)
                begin
                    if (phase_next == PH_BAUD && acc_next != '0)
                    begin
                        baud_next = acc_next;
                    end
                    phase_next = PH_BETWEEN;
                    ended_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_BETWEEN;
            match_reg     <= '0;
            acc_reg       <= '0;
            en_reg        <= 1'b0;
            port_reg      <= '0;
            baud_reg      <= cos_pkg::RESET_BAUD;
            ended_reg     <= 1'b0;
            dflt_baud_reg <= cos_pkg::RESET_BAUD;
        end
        else
        begin
            if (chars.ready)
            begin
                s1_valid_reg <= chars.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (settings.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                phase_reg <= phase_next;
                match_reg <= match_next;
                acc_reg   <= acc_next;
                en_reg    <= en_next;
                port_reg  <= port_next;
                baud_reg  <= baud_next;
                ended_reg <= ended_next;
            end
            if (cfg_we)
            begin
                dflt_baud_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            s1_char_reg  <= chars.char_byte;
            s1_first_reg <= chars.first_byte;
            s1_last_reg  <= chars.last_byte;
        end
    end

    assign settings.valid           = out_valid_reg;
    assign settings.console_enabled = en_reg;
    assign settings.console_port    = port_reg;
    assign settings.console_baud    = baud_reg;
    assign settings.line_done       = ended_reg;

    // The port is selected exactly when the console is enabled.
    a_port_follows_enable: assert property (@(posedge clk) disable iff (!rst_n)
        en_reg == (port_reg == cos_pkg::PORT_A || port_reg == cos_pkg::PORT_B))
        else $error("console port does not match the enable flag");

    // A baud value is only gathered after a selecting digit enabled the console.
    a_baud_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BAUD) |-> en_reg)
        else $error("baud accumulation without an enabled console");

    // Once the line has ended, bytes without a new-line flag leave the settings alone.
    a_ended_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && ended_reg && !s1_first_reg)
        |=> ($stable(en_reg) && $stable(port_reg) && $stable(baud_reg) && ended_reg))
        else $error("settings changed after the end of the line");

endmodule
`default_nettype wire
